### sv/stc_pkg.sv
// shared types, constants and character helpers for the script token classifier
package stc_pkg;

    localparam int CHAR_BITS     = 16;
    localparam int LA_DEPTH      = 9;
    localparam int KW_COUNT      = 8;
    localparam int KW_LONGEST    = 8;
    localparam int MAX_RESULTS   = 10;
    localparam int RUN_BITS      = 16;
    localparam int MAX_TOKEN_LEN = 65535;

    typedef logic [CHAR_BITS-1:0] char_t;
    typedef char_t la_buf_t [LA_DEPTH];
    typedef logic [3:0] la_cnt_t;
    typedef logic [RUN_BITS-1:0] run_t;

    // token classes, also used as scan modes
    localparam logic [2:0] CLS_DEFAULT = 3'd0;
    localparam logic [2:0] CLS_COMMENT = 3'd1;
    localparam logic [2:0] CLS_STRING  = 3'd2;
    localparam logic [2:0] CLS_NUMBER  = 3'd3;
    localparam logic [2:0] CLS_KEYWORD = 3'd4;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_COMMENT = 2'd1;
    localparam logic [1:0] MODE_STRING  = 2'd2;
    localparam logic [1:0] MODE_NUMBER  = 2'd3;

    localparam char_t CH_TAB   = char_t'(9);
    localparam char_t CH_LF    = char_t'(10);
    localparam char_t CH_CR    = char_t'(13);
    localparam char_t CH_SPACE = char_t'(32);
    localparam char_t CH_QUOTE = char_t'(34);
    localparam char_t CH_DOT   = char_t'(46);
    localparam char_t CH_SLASH = char_t'(47);
    localparam char_t CH_ZERO  = char_t'(48);
    localparam char_t CH_NINE  = char_t'(57);

    // keyword text, last character in the low byte
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'("break"), 64'("else"), 64'("for"), 64'("function"),
        64'("if"), 64'("return"), 64'("var"), 64'("while")
    };
    localparam la_cnt_t KW_LEN [KW_COUNT] = '{
        4'd5, 4'd4, 4'd3, 4'd8, 4'd2, 4'd6, 4'd3, 4'd5
    };

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic iter;
        logic final_emit;
        logic flush;
    } stc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic buf_empty;
        logic stall_wait;
        logic emit;
        logic push_block;
        logic open_tok;
        logic final_flag;
    } stc_stat_t;

    function automatic logic is_space(input char_t c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

    function automatic logic is_digit(input char_t c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // true if the first len buffered characters spell a keyword
    function automatic logic kw_match(input la_buf_t b, input la_cnt_t len);
        logic hit;
        logic ok;
        hit = 1'b0;
        for (int w = 0; w < KW_COUNT; w++)
        begin
            ok = (KW_LEN[w] == len);
            for (int i = 0; i < KW_LONGEST; i++)
            begin
                if (i < int'(KW_LEN[w]))
                begin
                    if (b[i] != char_t'(KW_TEXT[w][8*(int'(KW_LEN[w])-1-i) +: 8]))
                    begin
                        ok = 1'b0;
                    end
                end
            end
            hit = hit | ok;
        end
        return hit;
    endfunction

endpackage

### sv/script_token_classifier_unit.sv
// top level of the script token classifier: controller and datapath
//
//  channel | direction | handshake         | payload
//  s_axis  | in        | s_tvalid/s_tready | tdata char_code, tlast end_of_text
//  m_axis  | out       | m_tvalid/m_tready | tdata class+length, tlast, tuser
//
// one item passes through a load state, scan iterations of the lookahead
// buffer until one finds it empty or waiting for more characters, an end
// state and a flush state; a new character is taken only in the idle state.
// one result per cycle at most, while the output does not hold the scan.
// reset clears buffer count, scan state and all valid flags.
// a stalled output holds the scan only when a result has nowhere to go.
module script_token_classifier_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] char_code
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [2:0] token_class, [18:3] token_length, zero fill
    output logic        m_tlast,   // last_of_run
    output logic        m_tuser    // text_done
);
    import stc_pkg::*;

    stc_cmd_t    cmd;
    stc_stat_t   stat;
    logic [2:0]  token_class;
    logic [15:0] token_length;

    stc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    stc_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_code    (s_tdata),
        .end_of_text  (s_tlast),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .token_class  (token_class),
        .token_length (token_length),
        .last_of_run  (m_tlast),
        .text_done    (m_tuser)
    );

    // output packing
    assign m_tdata = {5'd0, token_length, token_class};

endmodule

### sv/stc_ctrl.sv
// controller state machine: load, scan iterations, end of step, result flush
module stc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  stc_pkg::stc_stat_t stat,
    output stc_pkg::stc_cmd_t  cmd
);
    import stc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_STEP  = 2'd1;
    localparam logic [1:0] ST_END   = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (stat.buf_empty || stat.stall_wait)
                begin
                    state_next = ST_END;
                end
                else if (!(stat.emit && stat.push_block))
                begin
                    cmd.iter = 1'b1;
                end
            end
            ST_END:
            begin
                if (stat.final_flag && stat.open_tok)
                begin
                    if (!stat.push_block)
                    begin
                        cmd.final_emit = 1'b1;
                        state_next     = ST_FLUSH;
                    end
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!stat.push_block)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### sv/stc_datapath.sv
// datapath: lookahead buffer, scan state, token decision and result registers
module stc_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        char_code,
    input  logic               end_of_text,
    input  stc_pkg::stc_cmd_t  cmd,
    output stc_pkg::stc_stat_t stat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         token_class,
    output logic [15:0]        token_length,
    output logic               last_of_run,
    output logic               text_done
);
    import stc_pkg::*;

    la_buf_t     buf_reg;
    la_cnt_t     cnt_reg;
    logic [1:0]  mode_reg;
    run_t        run_reg;
    logic        final_reg;
    logic [3:0]  emit_cnt_reg;
    logic        hold_valid_reg;
    logic [2:0]  hold_cls_reg;
    logic [15:0] hold_len_reg;
    logic        out_valid_reg;
    logic [2:0]  out_cls_reg;
    logic [15:0] out_len_reg;
    logic        out_last_reg;
    logic        out_done_reg;

    char_t       c0;
    char_t       c1;
    logic [16:0] r1;
    logic        em;
    logic [2:0]  em_cls;
    logic [15:0] em_len;
    la_cnt_t     drop;
    logic [1:0]  mode_next;
    run_t        run_next;
    logic        wt;
    la_cnt_t     sp_k;
    logic        emit_ok;
    logic        out_free;
    logic        push;
    logic [2:0]  push_cls;
    logic [15:0] push_len;

    assign c0 = buf_reg[0];
    assign c1 = buf_reg[1];
    assign r1 = {1'b0, run_reg} + 17'd1;

    // first whitespace at position one or later, else the count
    always_comb
    begin
        sp_k = cnt_reg;
        for (int j = LA_DEPTH - 1; j >= 1; j--)
        begin
            if ((4'(j) < cnt_reg) && is_space(buf_reg[j]))
            begin
                sp_k = 4'(j);
            end
        end
    end

    // one scan iteration on the front of the buffer
    always_comb
    begin
        em        = 1'b0;
        em_cls    = CLS_DEFAULT;
        em_len    = 16'd1;
        drop      = 4'd0;
        mode_next = mode_reg;
        run_next  = run_reg;
        wt        = 1'b0;
        case (mode_reg)
            MODE_COMMENT, MODE_NUMBER:
            begin
                if ((mode_reg == MODE_COMMENT) ? (c0 == CH_LF || c0 == CH_CR)
                                               : !(is_digit(c0) || c0 == CH_DOT))
                begin
                    em        = (run_reg != '0);
                    em_cls    = {1'b0, mode_reg};
                    em_len    = run_reg;
                    mode_next = MODE_IDLE;
                    run_next  = '0;
                end
                else
                begin
                    drop = 4'd1;
                    if (r1 >= 17'(MAX_TOKEN_LEN))
                    begin
                        em       = 1'b1;
                        em_cls   = {1'b0, mode_reg};
                        em_len   = r1[15:0];
                        run_next = '0;
                    end
                    else
                    begin
                        run_next = r1[15:0];
                    end
                end
            end
            MODE_STRING:
            begin
                drop = 4'd1;
                if (c0 == CH_QUOTE)
                begin
                    em        = 1'b1;
                    em_cls    = CLS_STRING;
                    em_len    = r1[15:0];
                    mode_next = MODE_IDLE;
                    run_next  = '0;
                end
                else if (r1 >= 17'(MAX_TOKEN_LEN))
                begin
                    em       = 1'b1;
                    em_cls   = CLS_STRING;
                    em_len   = r1[15:0];
                    run_next = '0;
                end
                else
                begin
                    run_next = r1[15:0];
                end
            end
            default:
            begin
                if (c0 == CH_SLASH)
                begin
                    if (cnt_reg < 4'd2 && !final_reg)
                    begin
                        wt = 1'b1;
                    end
                    else if (cnt_reg >= 4'd2 && c1 == CH_SLASH)
                    begin
                        mode_next = MODE_COMMENT;
                        run_next  = run_t'(2);
                        drop      = 4'd2;
                    end
                    else
                    begin
                        em   = 1'b1;
                        drop = 4'd1;
                    end
                end
                else if (c0 == CH_QUOTE || is_digit(c0))
                begin
                    mode_next = (c0 == CH_QUOTE) ? MODE_STRING : MODE_NUMBER;
                    run_next  = run_t'(1);
                    drop      = 4'd1;
                end
                else if (is_space(c0))
                begin
                    em   = 1'b1;
                    drop = 4'd1;
                end
                else if (sp_k == cnt_reg && !final_reg && cnt_reg <= 4'(KW_LONGEST))
                begin
                    wt = 1'b1;
                end
                else if (sp_k <= 4'(KW_LONGEST) && kw_match(buf_reg, sp_k))
                begin
                    em     = 1'b1;
                    em_cls = CLS_KEYWORD;
                    em_len = 16'(sp_k);
                    drop   = sp_k;
                end
                else
                begin
                    em   = 1'b1;
                    drop = 4'd1;
                end
            end
        endcase
    end

    // result push into the hold register
    assign emit_ok  = emit_cnt_reg < 4'(MAX_RESULTS);
    assign out_free = !out_valid_reg || out_ready;
    assign push     = (cmd.iter && em && emit_ok) || (cmd.final_emit && emit_ok);
    assign push_cls = cmd.final_emit ? {1'b0, mode_reg} : em_cls;
    assign push_len = cmd.final_emit ? run_reg : em_len;

    // status toward the controller
    always_comb
    begin
        stat.buf_empty  = (cnt_reg == '0);
        stat.stall_wait = wt;
        stat.emit       = em && emit_ok;
        stat.push_block = hold_valid_reg && !out_free;
        stat.open_tok   = (mode_reg != MODE_IDLE) && (run_reg != '0);
        stat.final_flag = final_reg;
    end

    // lookahead buffer storage
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (cnt_reg < 4'(LA_DEPTH))
            begin
                buf_reg[cnt_reg] <= char_code[CHAR_BITS-1:0];
            end
        end
        else if (cmd.iter)
        begin
            for (int j = 0; j < LA_DEPTH; j++)
            begin
                if ((5'(j) + {1'b0, drop}) < 5'(LA_DEPTH))
                begin
                    buf_reg[j] <= buf_reg[4'(j) + drop];
                end
            end
        end
    end

    // scan state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            mode_reg     <= MODE_IDLE;
            run_reg      <= '0;
            final_reg    <= 1'b0;
            emit_cnt_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                final_reg    <= end_of_text;
                emit_cnt_reg <= '0;
                if (cnt_reg < 4'(LA_DEPTH))
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                end
            end
            if (cmd.iter)
            begin
                cnt_reg  <= (drop >= cnt_reg) ? '0 : cnt_reg - drop;
                mode_reg <= mode_next;
                run_reg  <= run_next;
            end
            if (push)
            begin
                emit_cnt_reg <= emit_cnt_reg + 4'd1;
            end
            if (cmd.flush && final_reg)
            begin
                cnt_reg  <= '0;
                mode_reg <= MODE_IDLE;
                run_reg  <= '0;
            end
        end
    end

    // hold and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                hold_valid_reg <= 1'b1;
                if (hold_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                end
                else if (out_valid_reg && out_ready)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            else if (cmd.flush && hold_valid_reg)
            begin
                hold_valid_reg <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            hold_cls_reg <= push_cls;
            hold_len_reg <= push_len;
        end
        if ((push || cmd.flush) && hold_valid_reg)
        begin
            out_cls_reg  <= hold_cls_reg;
            out_len_reg  <= hold_len_reg;
            out_last_reg <= cmd.flush;
            out_done_reg <= cmd.flush && final_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign token_class  = out_cls_reg;
    assign token_length = out_len_reg;
    assign last_of_run  = out_last_reg;
    assign text_done    = out_done_reg;

endmodule

### test/tb_top.sv
// self-checking testbench for the script token classifier unit
`timescale 1ns / 100ps

module tb_top;

    import stc_pkg::*;

    typedef struct packed {
        logic [2:0]  cls;
        logic [15:0] len;
        logic        run_end;
        logic        done;
    } token_t;

    typedef struct {
        logic [15:0] ch;
        logic        eot;
        int          n_exp;     // -1: use predictor only
        token_t      t0;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    // predictor state
    logic [15:0] pend_chars [LA_DEPTH];
    int          pend_cnt;
    logic [1:0]  mode;
    int          tok_run;

    token_t      step_toks [$];
    token_t      expected_tokens [$];
    int          errors;
    bit          stim_done;

    script_token_classifier_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // push one token for the current character
    function automatic void add_token(logic [2:0] c, int n);
        token_t t;
        if (step_toks.size() >= MAX_RESULTS)
            return;
        t.cls = c;
        t.len = n[15:0];
        t.run_end = 1'b0;
        t.done = 1'b0;
        step_toks.push_back(t);
    endfunction

    function automatic bit blank(logic [15:0] c);
        return c == 16'd32 || c == 16'd9 || c == 16'd10 || c == 16'd13;
    endfunction

    function automatic bit numeral(logic [15:0] c);
        return c >= 16'd48 && c <= 16'd57;
    endfunction

    function automatic void shift_out(int k);
        if (k >= pend_cnt)
        begin
            pend_cnt = 0;
            return;
        end
        for (int i = 0; i < pend_cnt - k; i++)
            pend_chars[i] = pend_chars[i + k];
        pend_cnt -= k;
    endfunction

    function automatic bit spells_keyword(int n);
        string words [8];
        words = '{"break", "else", "for", "function", "if", "return", "var", "while"};
        foreach (words[w])
        begin
            if (words[w].len() == n)
            begin
                bit same;
                same = 1'b1;
                for (int i = 0; i < n; i++)
                    if (pend_chars[i] != 16'(words[w][i]))
                        same = 1'b0;
                if (same)
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void grow_run();
        tok_run++;
        if (tok_run >= MAX_TOKEN_LEN)
        begin
            add_token({1'b0, mode}, tok_run);
            tok_run = 0;
        end
    endfunction

    // feed one char to the open token, 1 if consumed
    function automatic bit open_token_char(logic [15:0] c);
        if (mode == MODE_COMMENT)
        begin
            if (c == 16'd10 || c == 16'd13)
            begin
                if (tok_run > 0)
                    add_token(CLS_COMMENT, tok_run);
                mode = MODE_IDLE;
                tok_run = 0;
                return 1'b0;
            end
            grow_run();
            return 1'b1;
        end
        if (mode == MODE_STRING)
        begin
            tok_run++;
            if (c == 16'd34)
            begin
                add_token(CLS_STRING, tok_run);
                mode = MODE_IDLE;
                tok_run = 0;
            end
            else if (tok_run >= MAX_TOKEN_LEN)
            begin
                add_token(CLS_STRING, tok_run);
                tok_run = 0;
            end
            return 1'b1;
        end
        if (numeral(c) || c == 16'd46)
        begin
            grow_run();
            return 1'b1;
        end
        if (tok_run > 0)
            add_token(CLS_NUMBER, tok_run);
        mode = MODE_IDLE;
        tok_run = 0;
        return 1'b0;
    endfunction

    // decide the front char between tokens, 0 to wait
    function automatic bit decide_front(bit eot);
        logic [15:0] c;
        int k;
        c = pend_chars[0];
        if (c == 16'd47)
        begin
            if (pend_cnt < 2 && !eot)
                return 1'b0;
            if (pend_cnt >= 2 && pend_chars[1] == 16'd47)
            begin
                mode = MODE_COMMENT;
                tok_run = 2;
                shift_out(2);
                return 1'b1;
            end
            add_token(CLS_DEFAULT, 1);
            shift_out(1);
            return 1'b1;
        end
        if (c == 16'd34 || numeral(c))
        begin
            mode = (c == 16'd34) ? MODE_STRING : MODE_NUMBER;
            tok_run = 1;
            shift_out(1);
            return 1'b1;
        end
        if (blank(c))
        begin
            add_token(CLS_DEFAULT, 1);
            shift_out(1);
            return 1'b1;
        end
        for (k = 1; k < pend_cnt; k++)
            if (blank(pend_chars[k]))
                break;
        if (k == pend_cnt && !eot && pend_cnt <= KW_LONGEST)
            return 1'b0;
        if (k <= KW_LONGEST && spells_keyword(k))
        begin
            add_token(CLS_KEYWORD, k);
            shift_out(k);
            return 1'b1;
        end
        add_token(CLS_DEFAULT, 1);
        shift_out(1);
        return 1'b1;
    endfunction

    function automatic void clear_scan();
        pend_cnt = 0;
        mode = MODE_IDLE;
        tok_run = 0;
    endfunction

    // predict the tokens caused by one character
    function automatic void classify_char(logic [15:0] c, bit eot);
        step_toks.delete();
        if (pend_cnt < LA_DEPTH)
        begin
            pend_chars[pend_cnt] = c;
            pend_cnt++;
        end
        while (pend_cnt > 0)
        begin
            if (mode != MODE_IDLE)
            begin
                if (open_token_char(pend_chars[0]))
                    shift_out(1);
            end
            else if (!decide_front(eot))
                break;
        end
        if (eot)
        begin
            if (mode != MODE_IDLE && tok_run > 0)
                add_token({1'b0, mode}, tok_run);
            clear_scan();
        end
        if (step_toks.size() > 0)
        begin
            step_toks[$].run_end = 1'b1;
            step_toks[$].done = eot;
        end
    endfunction

    stim_row_t rows [$];

    function automatic void add_row(logic [15:0] c, logic e, int n = -1,
                                    logic [2:0] k = 0, int l = 0);
        stim_row_t r;
        r.ch = c;
        r.eot = e;
        r.n_exp = n;
        r.t0 = '{k, l[15:0], 1'b1, e};
        rows.push_back(r);
    endfunction

    function automatic void add_text(string s, bit close);
        for (int i = 0; i < s.len(); i++)
            add_row(16'(s[i]), close && i == s.len() - 1);
    endfunction

    // send one char, checking directed expectations where given
    task automatic send_char(stim_row_t r);
        classify_char(r.ch, r.eot);
        if (r.n_exp >= 0)
        begin
            if (step_toks.size() != r.n_exp
                || (r.n_exp == 1 && step_toks[0] != r.t0))
            begin
                $display("%0t directed row %h: expected %0d token %p, got %p",
                         $time, r.ch, r.n_exp, r.t0, step_toks);
                errors++;
            end
        end
        foreach (step_toks[i])
            expected_tokens.push_back(step_toks[i]);
        s_tdata <= r.ch;
        s_tlast <= r.eot;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // sender gap after a burst
    task automatic maybe_gap(ref int burst);
        int gap;
        if (burst > 0)
        begin
            burst--;
            return;
        end
        gap = $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        burst = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 8);
    endtask

    function automatic logic [15:0] pick_char();
        string alpha;
        int sel;
        alpha = "/\"0123456789. \t\n\rbreaklsfoun ctiwhvx";
        sel = $urandom_range(0, 19);
        if (sel == 0)
            return 16'($urandom_range(0, 65535));
        if (sel == 1)
            return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        return 16'(alpha[$urandom_range(0, alpha.len() - 1)]);
    endfunction

    function automatic string pick_phrase();
        string p [12];
        p = '{"if ", "else\n", "while ", "for", "function ", "return\t", "var ",
              "break\r", "// note\n", "\"str x\"", "3.14 ", "xif "};
        return p[$urandom_range(0, 11)];
    endfunction

    // stimulus
    initial
    begin
        int burst;
        string txt;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        errors = 0;
        stim_done = 1'b0;
        burst = 0;
        clear_scan();
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows: extremes, each class, single slash, long word, flush
        add_row(16'h0000, 1'b1, 1, CLS_DEFAULT, 1);
        add_row(16'hffff, 1'b1, 1, CLS_DEFAULT, 1);
        add_row(16'd32, 1'b0, 1, CLS_DEFAULT, 1);
        add_row(16'd47, 1'b1, 1, CLS_DEFAULT, 1);
        add_text("if", 1'b1);
        add_text("//c\n", 1'b0);
        add_text("\"s\"", 1'b0);
        add_text("1.2 ", 1'b0);
        add_text("functions ", 1'b0);
        add_text("\"open", 1'b1);
        foreach (rows[i])
            send_char(rows[i]);
        s_tvalid <= 1'b0;
        @(posedge clk);

        // random part: mostly phrases, some noise, unterminated texts
        for (int n = 0; n < 500; )
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                txt = "";
                txt = {txt, " "};
                txt[0] = 8'(pick_char());
                if (pick_char() > 16'd255 || txt[0] == 8'd0)
                    txt = "";
            end
            else
                txt = pick_phrase();
            for (int i = 0; i < txt.len(); i++)
            begin
                stim_row_t r;
                r.ch = $urandom_range(0, 9) == 0 ? pick_char() : 16'(txt[i]);
                r.eot = $urandom_range(0, 40) == 0;
                r.n_exp = -1;
                send_char(r);
                n++;
                maybe_gap(burst);
            end
            if (n > 250 && n < 262)
            begin
                // hold off until the output has drained
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (expected_tokens.size() != 0)
                    @(posedge clk);
            end
        end
        begin
            stim_row_t r;
            r.ch = 16'd32;
            r.eot = 1'b1;
            r.n_exp = -1;
            send_char(r);
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver stall pattern and result check
    initial
    begin
        int phase;
        token_t got;
        token_t want;
        m_tready = 1'b0;
        phase = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got = '{m_tdata[2:0], m_tdata[18:3], m_tlast, m_tuser};
                if (expected_tokens.size() == 0)
                begin
                    $display("%0t unexpected token: got %p", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (got != want)
                    begin
                        $display("%0t token mismatch: expected %p, got %p",
                                 $time, want, got);
                        errors++;
                    end
                end
            end
            phase = (phase + 1) % 64;
            m_tready <= (phase < 20) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    // end of run
    initial
    begin
        wait (stim_done);
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);
        if (errors == 0 && expected_tokens.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // timeout
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
